// ===== design/delaunay_empty_circle_test_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the empty-circumcircle test block.
// Every macro expects signals named clk and rst in the using module.
// ----------------------------------------------------------------------------
`ifndef DELAUNAY_EMPTY_CIRCLE_TEST_MACROS_SVH
`define DELAUNAY_EMPTY_CIRCLE_TEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DECT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DECT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dect_pkg.sv =====
// ----------------------------------------------------------------------------
// dect_pkg
// Shared constants, codes and control structures of the empty-circle test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dect_pkg;

  localparam int IDX_W     = 6;
  localparam int COUNT_W   = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd3;
  localparam int CENTER_W  = 32;
  // Squared operands at or above 2**SQ_ARG_W saturate to 2**(2*SQ_ARG_W).
  localparam int SQ_ARG_W  = 31;
  localparam int SQ_W      = 2 * SQ_ARG_W + 1;
  localparam int R2_W      = SQ_W + 1;
  localparam int MUL_STEPS = 10;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  typedef enum logic [1:0] {
    VTX_A,
    VTX_B,
    VTX_C
  } vtx_t;

  // Setup multiply steps, issued in this order.
  typedef enum logic [3:0] {
    MOP_D_POS,
    MOP_D_NEG,
    MOP_L2_X,
    MOP_L2_Y,
    MOP_L3_X,
    MOP_L3_Y,
    MOP_NX_POS,
    MOP_NX_NEG,
    MOP_NY_POS,
    MOP_NY_NEG
  } mul_op_t;

  typedef struct packed {
    logic               capture;
    logic               fetch_issue;
    vtx_t               fetch_sel;
    logic               diff_load;
    logic               mul_issue;
    mul_op_t            mul_op;
    logic               div_start;
    logic               div_sel_y;
    logic               rad_load;
    logic               r2_load;
    logic               scan_issue;
    logic [COUNT_W-1:0] scan_idx;
    logic               out_load;
  } dect_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic div_done;
  } dect_stat_t;

endpackage

// ===== design/dect_item_if.sv =====
// ----------------------------------------------------------------------------
// dect_item_if
// Input channel: point writes and triangle tests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dect_item_if #(
  parameter int COORD_W = 18
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [dect_pkg::IDX_W-1:0]   index_a;
  logic [dect_pkg::IDX_W-1:0]   index_b;
  logic [dect_pkg::IDX_W-1:0]   index_c;
  logic signed [COORD_W-1:0]    point_x;
  logic signed [COORD_W-1:0]    point_y;
  logic                         point_frame;

  modport source (
    output valid, cmd, index_a, index_b, index_c, point_x, point_y, point_frame,
    input  ready
  );
  modport sink (
    input  valid, cmd, index_a, index_b, index_c, point_x, point_y, point_frame,
    output ready
  );
endinterface

// ===== design/dect_result_if.sv =====
// ----------------------------------------------------------------------------
// dect_result_if
// Output channel: one result per accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dect_result_if #(
  parameter int RAD_W = 48
);
  logic                                valid;
  logic                                ready;
  logic                                empty_circle;
  logic                                touches_frame;
  logic                                degenerate;
  logic signed [dect_pkg::CENTER_W-1:0] center_x;
  logic signed [dect_pkg::CENTER_W-1:0] center_y;
  logic [RAD_W-1:0]                    radius_sq;

  modport source (
    output valid, empty_circle, touches_frame, degenerate, center_x, center_y,
           radius_sq,
    input  ready
  );
  modport sink (
    input  valid, empty_circle, touches_frame, degenerate, center_x, center_y,
           radius_sq,
    output ready
  );
endinterface

// ===== design/dect_div.sv =====
// ----------------------------------------------------------------------------
// dect_div
// Restoring divider, one quotient bit per cycle: num / (2*den), rounded to
// nearest with ties away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dect_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 38
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W:0]   quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   dvd;
  logic [DEN_W+1:0]   rem;
  logic [DEN_W:0]     dvs;
  logic               neg;
  logic [NUM_W-1:0]   abs_num;
  logic [DEN_W-1:0]   abs_den;
  logic [DEN_W+1:0]   trial;
  logic               fits;

  always_comb begin
    abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    abs_den = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    trial   = {rem[DEN_W:0], dvd[NUM_W-1]};
    fits    = trial >= {1'b0, dvs};
    quo     = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // Adding |den| before dividing by 2|den| gives the rounding.
      dvd <= abs_num + NUM_W'(abs_den);
      dvs <= {abs_den, 1'b0};
      rem <= '0;
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      dvd <= {dvd[NUM_W-2:0], fits};
    end
  end
endmodule

// ===== design/dect_dp.sv =====
// ----------------------------------------------------------------------------
// dect_dp
// Datapath: point store, setup multiplier, divider, scan pipeline and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dect_dp #(
  parameter int MAX_POINTS      = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  dect_pkg::dect_cmd_t                       ctl,
  output dect_pkg::dect_stat_t                      stat,
  input  logic                                      cmd,
  input  logic [dect_pkg::IDX_W-1:0]                index_a,
  input  logic [dect_pkg::IDX_W-1:0]                index_b,
  input  logic [dect_pkg::IDX_W-1:0]                index_c,
  input  logic signed [COORD_FRAC_BITS+1:0]         point_x,
  input  logic signed [COORD_FRAC_BITS+1:0]         point_y,
  input  logic                                      point_frame,
  output logic                                      empty_circle,
  output logic                                      touches_frame,
  output logic                                      degenerate,
  output logic signed [dect_pkg::CENTER_W-1:0]      center_x,
  output logic signed [dect_pkg::CENTER_W-1:0]      center_y,
  output logic [2*COORD_FRAC_BITS+15:0]             radius_sq
);
  import dect_pkg::*;

  localparam int CW = COORD_FRAC_BITS + 2;  // coordinate
  localparam int DW = CW + 1;               // coordinate difference
  localparam int PW = 2 * DW;               // determinant, squared lengths
  localparam int NW = 3 * DW;               // center numerators
  localparam int UW = NW + 1;               // center offset
  localparam int FW = UW + 1;               // full center
  localparam int QW = FW + 1;               // point to center offset
  localparam int RW = 2 * COORD_FRAC_BITS + 16;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int EW = AW + IDX_W;
  localparam int SW = AW + COUNT_W;
  localparam logic signed [FW-1:0] C_MAX = FW'(2147483647);
  localparam logic signed [FW-1:0] C_MIN = -C_MAX - FW'(1);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 frame;
  } pt_t;

  pt_t mem [MAX_POINTS];
  pt_t rd_data;
  pt_t p1, p2, p3;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [IDX_W-1:0] ia, ib, ic;
  logic             is_test;
  logic             fetch_v, fetch_oob;
  vtx_t             fetch_sel_q;
  logic             sel_oob;

  logic signed [DW-1:0] dx2, dy2, dx3, dy3;
  logic signed [PW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [NW-1:0] prod;
  mul_op_t              prod_op;
  logic                 prod_v;
  logic signed [PW-1:0] d_acc, l2, l3;
  logic signed [NW-1:0] nx, ny;

  logic                 div_done, div_sel_q;
  logic signed [UW-1:0] quo, ux, uy;

  logic signed [FW-1:0] cx_full, cy_full;
  logic signed [QW-1:0] qx, qy;
  logic [SQ_W-1:0]      sx, sy;
  logic [R2_W-1:0]      r2, sq_sum;
  logic                 v0, v1, v2, intruder, skip;
  logic [R2_W:0]        r2_ext;

  function automatic logic idx_ok(input logic [IDX_W-1:0] i);
    idx_ok = {{AW{1'b0}}, i} < EW'(MAX_POINTS);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [EW-1:0] e;
    e = {{AW{1'b0}}, i};
    to_addr = e[AW-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq_sat(input logic signed [QW-1:0] v);
    logic [QW-1:0]           a;
    logic [2*SQ_ARG_W-1:0]   p;
    a = v[QW-1] ? QW'(-v) : QW'(v);
    p = a[SQ_ARG_W-1:0] * a[SQ_ARG_W-1:0];
    if (|a[QW-1:SQ_ARG_W]) begin
      sq_sat = {1'b1, {(SQ_W-1){1'b0}}};
    end else begin
      sq_sat = {1'b0, p};
    end
  endfunction

  function automatic logic signed [CENTER_W-1:0] sat32(input logic signed [FW-1:0] v);
    if (v > C_MAX) begin
      sat32 = C_MAX[CENTER_W-1:0];
    end else if (v < C_MIN) begin
      sat32 = C_MIN[CENTER_W-1:0];
    end else begin
      sat32 = v[CENTER_W-1:0];
    end
  endfunction

  // Memory addressing and write.
  always_comb begin
    logic [SW-1:0] se;
    se    = {{AW{1'b0}}, ctl.scan_idx};
    wr_en = ctl.capture && (cmd == CMD_WRITE) && idx_ok(index_a);
    if (ctl.scan_issue) begin
      rd_addr = se[AW-1:0];
      sel_oob = 1'b0;
    end else begin
      case (ctl.fetch_sel)
        VTX_A:   begin rd_addr = to_addr(ia); sel_oob = !idx_ok(ia); end
        VTX_B:   begin rd_addr = to_addr(ib); sel_oob = !idx_ok(ib); end
        VTX_C:   begin rd_addr = to_addr(ic); sel_oob = !idx_ok(ic); end
        default: begin rd_addr = to_addr(ia); sel_oob = !idx_ok(ia); end
      endcase
    end
    skip = ({1'b0, ia} == ctl.scan_idx) || ({1'b0, ib} == ctl.scan_idx) ||
           ({1'b0, ic} == ctl.scan_idx);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[to_addr(index_a)] <= '{x: point_x, y: point_y, frame: point_frame};
    end
    rd_data <= mem[rd_addr];
  end

  // Multiplier operand selection.
  always_comb begin
    case (ctl.mul_op)
      MOP_D_POS:  begin mul_a = PW'(dx2); mul_b = dy3; end
      MOP_D_NEG:  begin mul_a = PW'(dx3); mul_b = dy2; end
      MOP_L2_X:   begin mul_a = PW'(dx2); mul_b = dx2; end
      MOP_L2_Y:   begin mul_a = PW'(dy2); mul_b = dy2; end
      MOP_L3_X:   begin mul_a = PW'(dx3); mul_b = dx3; end
      MOP_L3_Y:   begin mul_a = PW'(dy3); mul_b = dy3; end
      MOP_NX_POS: begin mul_a = l2;       mul_b = dy3; end
      MOP_NX_NEG: begin mul_a = l3;       mul_b = dy2; end
      MOP_NY_POS: begin mul_a = l3;       mul_b = dx2; end
      MOP_NY_NEG: begin mul_a = l2;       mul_b = dx3; end
      default:    begin mul_a = '0;       mul_b = '0;  end
    endcase
    sq_sum = R2_W'(sx) + R2_W'(sy);
    r2_ext = {1'b0, r2};
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_v <= 1'b0;
      prod_v  <= 1'b0;
      v0      <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      fetch_v <= ctl.fetch_issue;
      prod_v  <= ctl.mul_issue;
      v0      <= ctl.scan_issue && !skip;
      v1      <= v0;
      v2      <= v1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      ia      <= index_a;
      ib      <= index_b;
      ic      <= index_c;
      is_test <= (cmd == CMD_TEST);
    end
    fetch_sel_q <= ctl.fetch_sel;
    fetch_oob   <= sel_oob;
    if (fetch_v) begin
      case (fetch_sel_q)
        VTX_A:   p1 <= fetch_oob ? '0 : rd_data;
        VTX_B:   p2 <= fetch_oob ? '0 : rd_data;
        VTX_C:   p3 <= fetch_oob ? '0 : rd_data;
        default: p1 <= fetch_oob ? '0 : rd_data;
      endcase
    end
    if (ctl.diff_load) begin
      dx2 <= DW'(p2.x) - DW'(p1.x);
      dy2 <= DW'(p2.y) - DW'(p1.y);
      dx3 <= DW'(p3.x) - DW'(p1.x);
      dy3 <= DW'(p3.y) - DW'(p1.y);
    end
    prod    <= mul_a * mul_b;
    prod_op <= ctl.mul_op;
    if (prod_v) begin
      case (prod_op)
        MOP_D_POS:  d_acc <= PW'(prod);
        MOP_D_NEG:  d_acc <= d_acc - PW'(prod);
        MOP_L2_X:   l2    <= PW'(prod);
        MOP_L2_Y:   l2    <= l2 + PW'(prod);
        MOP_L3_X:   l3    <= PW'(prod);
        MOP_L3_Y:   l3    <= l3 + PW'(prod);
        MOP_NX_POS: nx    <= prod;
        MOP_NX_NEG: nx    <= nx - prod;
        MOP_NY_POS: ny    <= prod;
        MOP_NY_NEG: ny    <= ny - prod;
        default:    d_acc <= d_acc;
      endcase
    end
    if (ctl.div_start) begin
      div_sel_q <= ctl.div_sel_y;
    end
    if (div_done) begin
      if (div_sel_q) begin
        uy <= quo;
      end else begin
        ux <= quo;
      end
    end
    // The squarers see the center offset first, then each scanned point.
    if (ctl.rad_load) begin
      cx_full <= FW'(p1.x) + FW'(ux);
      cy_full <= FW'(p1.y) + FW'(uy);
      qx      <= QW'(ux);
      qy      <= QW'(uy);
    end else if (v0) begin
      qx <= QW'(rd_data.x) - QW'(cx_full);
      qy <= QW'(rd_data.y) - QW'(cy_full);
    end
    sx <= sq_sat(qx);
    sy <= sq_sat(qy);
    if (ctl.r2_load) begin
      r2 <= sq_sum;
    end
    if (ctl.rad_load) begin
      intruder <= 1'b0;
    end else if (v2 && (sq_sum < r2)) begin
      intruder <= 1'b1;
    end
    if (ctl.out_load) begin
      empty_circle  <= is_test && !stat.d_zero && !intruder;
      touches_frame <= is_test && (p1.frame || p2.frame || p3.frame);
      degenerate    <= is_test && stat.d_zero;
      if (is_test && !stat.d_zero) begin
        center_x <= sat32(cx_full);
        center_y <= sat32(cy_full);
        if (r2_ext > {{(R2_W+1-RW){1'b0}}, {RW{1'b1}}}) begin
          radius_sq <= {RW{1'b1}};
        end else begin
          radius_sq <= r2[RW-1:0];
        end
      end else begin
        center_x  <= '0;
        center_y  <= '0;
        radius_sq <= '0;
      end
    end
  end

  assign stat.d_zero   = (d_acc == '0);
  assign stat.div_done = div_done;

  dect_div #(
    .NUM_W (NW),
    .DEN_W (PW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (ctl.div_sel_y ? ny : nx),
    .den   (d_acc),
    .done  (div_done),
    .quo   (quo)
  );
endmodule

// ===== design/dect_ctrl.sv =====
// ----------------------------------------------------------------------------
// dect_ctrl
// Controller: sequences fetch, setup, division, scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delaunay_empty_circle_test_macros.svh"

module dect_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            cfg_wr_en,
  input  logic [dect_pkg::COUNT_W-1:0]    cfg_wr_data,
  output dect_pkg::dect_cmd_t             ctl,
  input  dect_pkg::dect_stat_t            stat
);
  import dect_pkg::*;

  localparam int LIM_W = $clog2(MAX_POINTS + 1) + COUNT_W;
  localparam logic [3:0] MUL_LAST = 4'(MUL_STEPS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FETCH  = 9'b000000010,
    S_SETUP  = 9'b000000100,
    S_DIVX   = 9'b000001000,
    S_DIVY   = 9'b000010000,
    S_RADIUS = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_DRAIN  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [3:0]         step, step_next;
  logic [COUNT_W-1:0] scan_idx, scan_idx_next;
  logic [COUNT_W-1:0] point_count, lim;
  logic               out_valid_next;
  logic               accept;

  always_comb begin
    if ({{(LIM_W-COUNT_W){1'b0}}, point_count} > LIM_W'(MAX_POINTS)) begin
      lim = COUNT_W'(MAX_POINTS);
    end else begin
      lim = point_count;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl           = '0;
    ctl.capture   = accept;
    state_next    = state;
    step_next     = step;
    scan_idx_next = scan_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          step_next  = '0;
          state_next = (in_cmd == CMD_TEST) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        if (step < 4'd3) begin
          ctl.fetch_issue = 1'b1;
          ctl.fetch_sel   = vtx_t'(step[1:0]);
        end
        if (step == 4'd4) begin
          ctl.diff_load = 1'b1;
          step_next     = '0;
          state_next    = S_SETUP;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_SETUP: begin
        if (step < MUL_LAST) begin
          ctl.mul_issue = 1'b1;
          ctl.mul_op    = mul_op_t'(step);
        end
        if (step == MUL_LAST) begin
          step_next  = '0;
          state_next = stat.d_zero ? S_DONE : S_DIVX;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_DIVX: begin
        if (step == '0) begin
          ctl.div_start = 1'b1;
          step_next     = 4'd1;
        end else if (stat.div_done) begin
          step_next  = '0;
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (step == '0) begin
          ctl.div_start = 1'b1;
          ctl.div_sel_y = 1'b1;
          step_next     = 4'd1;
        end else if (stat.div_done) begin
          step_next  = '0;
          state_next = S_RADIUS;
        end
      end
      S_RADIUS: begin
        ctl.rad_load = (step == '0);
        if (step == 4'd2) begin
          ctl.r2_load   = 1'b1;
          scan_idx_next = '0;
          state_next    = S_SCAN;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_SCAN: begin
        if (scan_idx < lim) begin
          ctl.scan_issue = 1'b1;
          ctl.scan_idx   = scan_idx;
          scan_idx_next  = scan_idx + 7'd1;
        end else begin
          step_next  = '0;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (step == 4'd2) begin
          state_next = S_DONE;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      scan_idx    <= '0;
      out_valid   <= 1'b0;
      point_count <= COUNT_RESET;
    end else begin
      state     <= state_next;
      step      <= step_next;
      scan_idx  <= scan_idx_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
    end
  end

  `DECT_ASSERT_IMP(a_no_overwrite, ctl.out_load, !out_valid || out_ready, "result overwritten")
  `DECT_ASSERT_NXT(a_busy_after_accept, accept, !in_ready, "ready after accept")
  `DECT_ASSERT_IMP(a_scan_in_range, ctl.scan_issue, scan_idx < lim, "scan past limit")
endmodule

// ===== design/delaunay_empty_circle_test.sv =====
// ----------------------------------------------------------------------------
// delaunay_empty_circle_test
// Empty-circumcircle test over a stored point set, one result per item.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Transaction
// item     in         point write or triangle test (valid/ready)
// result   out        flags, circumcenter, squared radius (valid/ready)
// cfg      in         point_count write (cfg_wr_en, no handshake)
//
// A point write goes straight to the result hand-off. A triangle test scans
// N stored points, where N is point_count capped at MAX_POINTS; the two
// bit-serial divisions for the center dominate, followed by one stored point
// per cycle through the scan pipeline. A collinear triangle ends after the
// setup products.
// Reset is synchronous, clears the controller and loads COUNT_RESET into the
// count register; the point store holds no defined value until written.
// A result waits in the output register while the next transaction is taken;
// a stalled result channel only lengthens the final hand-off cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delaunay_empty_circle_test #(
  parameter int MAX_POINTS      = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  dect_item_if.sink                    item,
  dect_result_if.source                result,
  input  logic                         cfg_wr_en,
  input  logic [dect_pkg::COUNT_W-1:0] cfg_wr_data
);
  import dect_pkg::*;

  // The controller issues one command word per cycle; the datapath answers
  // with the determinant-zero flag and the divider completion pulse.
  dect_cmd_t  ctl;
  dect_stat_t stat;

  // The controller owns both handshakes and the point_count register. It
  // only accepts a transaction while idle, but a finished result may still
  // sit in the output register at that time.
  dect_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .in_cmd      (item.cmd),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .stat        (stat)
  );

  // The datapath holds the point store, the setup multiplier, the divider,
  // the three-stage distance pipeline and the result payload register.
  dect_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (item.cmd),
    .index_a       (item.index_a),
    .index_b       (item.index_b),
    .index_c       (item.index_c),
    .point_x       (item.point_x),
    .point_y       (item.point_y),
    .point_frame   (item.point_frame),
    .empty_circle  (result.empty_circle),
    .touches_frame (result.touches_frame),
    .degenerate    (result.degenerate),
    .center_x      (result.center_x),
    .center_y      (result.center_y),
    .radius_sq     (result.radius_sq)
  );
endmodule

// ===== tb/sv/tb_delaunay_empty_circle_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delaunay_empty_circle_test
// Self-checking testbench for the empty-circumcircle test block. Point writes
// and triangle tests are sent through the item channel. A predictor keeps its
// own copy of the point store and computes each expected result. The results
// are compared field by field, in order, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_delaunay_empty_circle_test;
  import dect_pkg::*;

  localparam int  STORE_DEPTH = 64;
  localparam int  FRAC_BITS   = 16;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam longint unsigned SQ_SAT_VALUE = 64'd1 << 62;
  localparam longint unsigned RADIUS_CAP   = (64'd1 << 48) - 1;

  // One transaction on the item channel.
  typedef struct {
    logic              cmd;
    logic [5:0]        index_a;
    logic [5:0]        index_b;
    logic [5:0]        index_c;
    logic signed [17:0] point_x;
    logic signed [17:0] point_y;
    logic              point_frame;
  } circle_item_t;

  // One transaction on the result channel.
  typedef struct {
    logic              empty_circle;
    logic              touches_frame;
    logic              degenerate;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [47:0]       radius_sq;
  } circle_res_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  dect_item_if   #(.COORD_W(18)) item_ch ();
  dect_result_if #(.RAD_W(48))   res_ch ();

  delaunay_empty_circle_test i_dut (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch.sink),
    .result      (res_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state: our own copy of the point store and the count register.
  longint     store_x [STORE_DEPTH];
  longint     store_y [STORE_DEPTH];
  logic       store_frame [STORE_DEPTH];
  int         scan_count;

  circle_item_t pending_items[$];
  circle_res_t  expected_results[$];

  int  gap_left;
  int  stall_left;
  bit  burst_mode;
  int  mismatch_cnt;
  int  test_cnt;
  int  write_cnt;
  int  degenerate_cnt;
  int  empty_cnt;
  int  result_cnt;
  longint cycle_cnt;

  // Clock: 20 ns period, starting low so the first rising edge comes after
  // the initial block has set up the cycle and mismatch counters.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Timeout guard: a hang in the block must still end the run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_delaunay_empty_circle_test: done, errors");
      $finish;
    end
  end

  // Appends one transaction to the driver's queue.
  function automatic void queue_item(circle_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // Squared magnitude, saturated once the operand reaches 2**31.
  function automatic longint unsigned sq_capped(longint v);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    if (mag >= (64'd1 << 31)) return SQ_SAT_VALUE;
    return mag * mag;
  endfunction

  // num / (2 * den), rounded to nearest with ties away from zero.
  function automatic longint half_quotient(longint num, longint den);
    longint unsigned an;
    longint unsigned ad;
    longint unsigned q;
    an = (num < 0) ? longint'(-num) : longint'(num);
    ad = (den < 0) ? longint'(-den) : longint'(den);
    q  = (an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Works out the result of one accepted transaction and updates the store.
  function automatic circle_res_t predict_circle(circle_item_t it);
    circle_res_t r;
    longint x1, y1, dx2, dy2, dx3, dy3, det, len2, len3, ux, uy;
    longint unsigned r2;
    int lim;
    bit empty;
    r = '{default: '0};
    if (it.cmd == CMD_WRITE) begin
      store_x[it.index_a]     = longint'(it.point_x);
      store_y[it.index_a]     = longint'(it.point_y);
      store_frame[it.index_a] = it.point_frame;
      return r;
    end
    r.touches_frame = store_frame[it.index_a] | store_frame[it.index_b] |
                      store_frame[it.index_c];
    x1  = store_x[it.index_a];
    y1  = store_y[it.index_a];
    dx2 = store_x[it.index_b] - x1;
    dy2 = store_y[it.index_b] - y1;
    dx3 = store_x[it.index_c] - x1;
    dy3 = store_y[it.index_c] - y1;
    det = dx2 * dy3 - dx3 * dy2;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    len2 = dx2 * dx2 + dy2 * dy2;
    len3 = dx3 * dx3 + dy3 * dy3;
    ux = half_quotient(len2 * dy3 - len3 * dy2, det);
    uy = half_quotient(len3 * dx2 - len2 * dx3, det);
    r2 = sq_capped(ux) + sq_capped(uy);
    lim = (scan_count > STORE_DEPTH) ? STORE_DEPTH : scan_count;
    empty = 1'b1;
    for (int m = 0; m < lim; m++) begin
      if (m != it.index_a && m != it.index_b && m != it.index_c && empty) begin
        if (sq_capped(store_x[m] - x1 - ux) + sq_capped(store_y[m] - y1 - uy) < r2)
          empty = 1'b0;
      end
    end
    r.empty_circle = empty;
    r.center_x     = 32'(clamp32(x1 + ux));
    r.center_y     = 32'(clamp32(y1 + uy));
    r.radius_sq    = (r2 > RADIUS_CAP) ? RADIUS_CAP[47:0] : r2[47:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in burst mode.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued transactions and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        circle_item_t acc;
        acc.cmd         = item_ch.cmd;
        acc.index_a     = item_ch.index_a;
        acc.index_b     = item_ch.index_b;
        acc.index_c     = item_ch.index_c;
        acc.point_x     = item_ch.point_x;
        acc.point_y     = item_ch.point_y;
        acc.point_frame = item_ch.point_frame;
        expected_results = {expected_results, predict_circle(acc)};
        if (acc.cmd == CMD_WRITE) write_cnt++;
        else test_cnt++;
      end
      if (item_ch.valid && !item_ch.ready) begin
        // Hold the current transaction until it is taken.
      end else if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        circle_item_t nxt;
        nxt = pending_items.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= nxt.cmd;
        item_ch.index_a     <= nxt.index_a;
        item_ch.index_b     <= nxt.index_b;
        item_ch.index_c     <= nxt.index_c;
        item_ch.point_x     <= nxt.point_x;
        item_ch.point_y     <= nxt.point_y;
        item_ch.point_frame <= nxt.point_frame;
        gap_left            <= pick_gap();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, and an in-order compare of each result.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        circle_res_t got;
        circle_res_t exp_r;
        got.empty_circle  = res_ch.empty_circle;
        got.touches_frame = res_ch.touches_frame;
        got.degenerate    = res_ch.degenerate;
        got.center_x      = res_ch.center_x;
        got.center_y      = res_ch.center_y;
        got.radius_sq     = res_ch.radius_sq;
        result_cnt++;
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result with nothing expected: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.empty_circle !== exp_r.empty_circle ||
              got.touches_frame !== exp_r.touches_frame ||
              got.degenerate !== exp_r.degenerate ||
              got.center_x !== exp_r.center_x || got.center_y !== exp_r.center_y ||
              got.radius_sq !== exp_r.radius_sq) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                       result_cnt, exp_r, got);
          end else begin
            if (got.degenerate) degenerate_cnt++;
            if (got.empty_circle) empty_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left   <= pick_gap();
      end
    end
  end

  function automatic circle_item_t make_write(int slot, int x, int y, bit frame);
    circle_item_t it;
    it.cmd         = CMD_WRITE;
    it.index_a     = slot[5:0];
    it.index_b     = $urandom_range(0, 63);
    it.index_c     = $urandom_range(0, 63);
    it.point_x     = x[17:0];
    it.point_y     = y[17:0];
    it.point_frame = frame;
    return it;
  endfunction

  function automatic circle_item_t make_test(int a, int b, int c);
    circle_item_t it;
    it.cmd         = CMD_TEST;
    it.index_a     = a[5:0];
    it.index_b     = b[5:0];
    it.index_c     = c[5:0];
    it.point_x     = 18'($urandom);
    it.point_y     = 18'($urandom);
    it.point_frame = $urandom_range(0, 1);
    return it;
  endfunction

  // Coordinates: mostly a small cluster so that circles catch other points,
  // some anywhere in range, a few on the extremes.
  function automatic int rand_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(0, 8191) - 4096;
    if (roll < 90) return $urandom_range(0, 262143) - 131072;
    case ($urandom_range(0, 3))
      0: return -131072;
      1: return 131071;
      2: return 0;
      default: return $urandom_range(0, 1) ? 1 : -1;
    endcase
  endfunction

  // Random part of one phase: mostly tests, a share of point writes, some
  // tests with repeated vertices and some built on a straight line.
  task automatic queue_random(int n);
    int roll, a, b, c, s, x0, y0, sx, sy;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
        queue_item(make_write($urandom_range(0, 63), rand_coord(),
                              rand_coord(), $urandom_range(0, 9) == 0));
      end else if (roll < 33) begin
        s  = $urandom_range(0, 61);
        x0 = $urandom_range(0, 2000) - 1000;
        y0 = $urandom_range(0, 2000) - 1000;
        sx = $urandom_range(0, 200) - 100;
        sy = $urandom_range(0, 200) - 100;
        for (int j = 0; j < 3; j++)
          queue_item(make_write(s + j, x0 + j * sx, y0 + j * sy, 1'b0));
        queue_item(make_test(s + 2, s, s + 1));
        k += 3;
      end else begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
        if (roll < 38) b = a;
        queue_item(make_test(a, b, c));
      end
    end
  endtask

  // Waits until the driver has nothing left and every result is back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
  endtask

  // The count register is only written while the block is idle.
  task automatic write_count(int value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[COUNT_W-1:0];
    scan_count  = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase_counts[8];
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = CMD_WRITE;
    item_ch.index_a     = '0;
    item_ch.index_b     = '0;
    item_ch.index_c     = '0;
    item_ch.point_x     = '0;
    item_ch.point_y     = '0;
    item_ch.point_frame = 1'b0;
    res_ch.ready        = 1'b0;
    scan_count          = COUNT_RESET;
    cycle_cnt           = 0;
    mismatch_cnt        = 0;
    burst_mode          = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_x[i]     = 0;
      store_y[i]     = 0;
      store_frame[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every slot first, so that no scan or vertex read ever lands on
    // a slot that was never written.
    write_count(STORE_DEPTH);
    for (int i = 0; i < STORE_DEPTH; i++)
      queue_item(make_write(i, rand_coord(), rand_coord(), i[3:0] == 0));

    // Directed part: extreme corners, repeated vertices, collinear points,
    // frame helper points, a near-collinear triangle with a far center and
    // a tiny triangle at the highest slot.
    queue_item(make_write(0, -131072, -131072, 1'b0));
    queue_item(make_write(1, 131071, -131072, 1'b0));
    queue_item(make_write(2, -131072, 131071, 1'b1));
    queue_item(make_test(0, 1, 2));
    queue_item(make_test(2, 1, 0));
    queue_item(make_test(0, 0, 1));
    queue_item(make_test(5, 5, 5));
    queue_item(make_write(3, 0, 0, 1'b0));
    queue_item(make_write(4, 131071, 1, 1'b0));
    queue_item(make_write(5, -131072, 0, 1'b0));
    queue_item(make_test(3, 4, 5));
    queue_item(make_write(6, 100, 100, 1'b0));
    queue_item(make_write(7, 200, 200, 1'b0));
    queue_item(make_test(3, 6, 7));
    queue_item(make_write(61, 1, 0, 1'b1));
    queue_item(make_write(62, 0, 1, 1'b0));
    queue_item(make_write(63, 0, 0, 1'b0));
    queue_item(make_test(63, 61, 62));
    queue_item(make_test(61, 62, 63));
    queue_item(make_test(1, 2, 3));

    // Random phases, the count register at its extremes and in between.
    phase_counts = '{0, 3, 127, 1, 20, 65, 64, 2};
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      burst_mode = (p % 3 == 2);
      queue_random(242);
    end
    wait_drained();
    repeat (300) @(posedge clk);

    $display("Covered %0d point writes and %0d triangle tests over 9 count settings.",
             write_cnt, test_cnt);
    $display("Results: %0d degenerate, %0d empty circles, %0d mismatches.",
             degenerate_cnt, empty_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("tb_delaunay_empty_circle_test: done, clean");
    end else begin
      $display("tb_delaunay_empty_circle_test: done, errors");
    end
    $finish;
  end

endmodule
